// File: rtl/hipr_pkg.sv
// Shared types and constants for the heap image pointer relocator.
`default_nettype none

package hipr_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CountW  = 56;
  localparam int unsigned BytesW  = 48;
  localparam int unsigned LitW    = 15;
  localparam int unsigned FmtLsb  = 24;
  localparam int unsigned FmtW    = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0]      TopOverflow = 8'hFF;
  localparam logic [FmtW-1:0] FmtPtrMax   = 5'd5;
  localparam logic [FmtW-1:0] FmtWeakPtr  = 5'd9;
  localparam logic [FmtW-1:0] FmtMethod   = 5'd24;
  localparam logic [LitW-1:0] LitMask     = 15'h7FFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OLD_BASE   = 2'd0,
    REG_NEW_BASE   = 2'd1,
    REG_HEAP_BYTES = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_OVERFLOW = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_CONV     = 2'd2,
    KIND_PASS     = 2'd3
  } word_kind_e;

  typedef enum logic [1:0] {
    CLS_RAW    = 2'd0,
    CLS_PTR    = 2'd1,
    CLS_METHOD = 2'd2
  } obj_class_e;

  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    word_kind_e       kind;
    logic             last;
  } hipr_res_t;

endpackage

`default_nettype wire

// File: rtl/heap_image_pointer_relocator.sv
// Top level of the heap image pointer relocator: registers, config and pipeline.
//
//   channel   dir   handshake                  contents
//   s_axis    in    s_axis_tvalid/tready       tdata: heap_word
//   m_axis    out   m_axis_tvalid/tready       tdata: word_out, tuser: word_kind,
//                                              tlast: object_end
//   cfg       in    cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One word per cycle sustained while m_axis does not stall. A word taken on
// s_axis is held in the input register, then moves to the result register
// and shows on m_axis from then on. The conversion adder and range compare
// between those two registers set the clock.
// Reset clears the parse state, the config registers and both valid flags.
// A stall on m_axis holds the result and backs up into the input register;
// cfg writes are always taken at once.
`default_nettype none

module heap_image_pointer_relocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [hipr_pkg::WordW-1:0]   s_axis_tdata,   // [63:0] heap_word
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [hipr_pkg::WordW-1:0]   m_axis_tdata,   // [63:0] word_out
  output logic      [1:0]                   m_axis_tuser,   // [1:0] word_kind
  output logic                              m_axis_tlast,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hipr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hipr_pkg::WordW-1:0]   cfg_data_i
);
  import hipr_pkg::*;

  logic [WordW-1:0]  old_base_q, new_base_q, delta_q;
  logic [WordW-1:0]  old_base_d, new_base_d;
  logic [BytesW-1:0] heap_bytes_q, heap_bytes_d;

  logic              in_valid_q, in_valid_d;
  logic [WordW-1:0]  in_word_q;
  logic              out_valid_q, out_valid_d;
  hipr_res_t         out_q;
  hipr_res_t         res;
  logic [WordW-1:0]  conv_word;
  logic              out_free, advance, s_acc;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    old_base_d   = old_base_q;
    new_base_d   = new_base_q;
    heap_bytes_d = heap_bytes_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OLD_BASE:   old_base_d   = cfg_data_i;
        REG_NEW_BASE:   new_base_d   = cfg_data_i;
        REG_HEAP_BYTES: heap_bytes_d = cfg_data_i[BytesW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_base_q   <= '0;
      new_base_q   <= '0;
      heap_bytes_q <= '0;
      delta_q      <= '0;
    end else begin
      old_base_q   <= old_base_d;
      new_base_q   <= new_base_d;
      heap_bytes_q <= heap_bytes_d;
      // offset follows the next base values, so it always matches the bases
      delta_q      <= new_base_d - old_base_d;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_acc ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_word_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  hipr_conv u_conv (
    .word_i       (in_word_q),
    .old_base_i   (old_base_q),
    .delta_i      (delta_q),
    .heap_bytes_i (heap_bytes_q),
    .word_o       (conv_word)
  );

  hipr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .word_i      (in_word_q),
    .conv_word_i (conv_word),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.word;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// File: rtl/hipr_conv.sv
// Tag conversion and pointer relocation of one heap word.
`default_nettype none

module hipr_conv (
  input  wire logic [hipr_pkg::WordW-1:0]  word_i,
  input  wire logic [hipr_pkg::WordW-1:0]  old_base_i,
  input  wire logic [hipr_pkg::WordW-1:0]  delta_i,
  input  wire logic [hipr_pkg::BytesW-1:0] heap_bytes_i,
  output logic      [hipr_pkg::WordW-1:0]  word_o
);
  import hipr_pkg::*;

  logic [WordW:0] diff;
  logic           in_range;

  // borrow out means the word lies below the old base
  assign diff     = {1'b0, word_i} - {1'b0, old_base_i};
  assign in_range = !diff[WordW] && (diff[WordW-1:BytesW] == '0)
                    && (diff[BytesW-1:0] < heap_bytes_i);

  always_comb begin
    word_o = word_i;
    if (word_i != '0 && !word_i[0]) begin
      case (word_i[2:0])
        3'd2:    word_o = {word_i[WordW-1:3], 3'b011};
        3'd4:    word_o = {word_i[WordW-1:3], 3'b101};
        3'd0:    if (in_range) word_o = word_i + delta_i;
        default: word_o = word_i;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/hipr_parse.sv
// Object boundary tracker: classifies each heap word and selects conversion.
`default_nettype none

module hipr_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic [hipr_pkg::WordW-1:0] word_i,
  input  wire logic [hipr_pkg::WordW-1:0] conv_word_i,
  output hipr_pkg::hipr_res_t             res_o
);
  import hipr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] pending_q, pending_d;
  logic [CountW-1:0] slots_q, slots_d;
  logic              pad_q, pad_d;
  obj_class_e        class_q, class_d;
  logic [LitW-1:0]   lits_q, lits_d;
  logic              first_q, first_d;

  logic [7:0]        top;
  logic [FmtW-1:0]   fmt;
  logic [CountW-1:0] hdr_count;
  logic [CountW-1:0] slots_dec;
  logic              conv;

  assign top       = word_i[WordW-1:WordW-8];
  assign fmt       = word_i[FmtLsb+FmtW-1:FmtLsb];
  // only a header right after an overflow word may carry the escape byte
  assign hdr_count = (phase_q == PH_HEADER && top == TopOverflow) ? pending_q
                                                                  : {48'd0, top};
  assign slots_dec = slots_q - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    slots_d   = slots_q;
    pad_d     = pad_q;
    class_d   = class_q;
    lits_d    = lits_q;
    first_d   = first_q;
    conv      = 1'b0;
    res_o.word = word_i;
    res_o.kind = KIND_PASS;
    res_o.last = 1'b0;

    unique case (phase_q)
      PH_BODY: begin
        if (!pad_q) begin
          if (class_q == CLS_PTR) begin
            conv = 1'b1;
          end else if (class_q == CLS_METHOD) begin
            if (first_q) begin
              conv = 1'b1;
            end else if (lits_q != '0) begin
              conv   = 1'b1;
              lits_d = lits_q - 1'b1;
            end
          end
        end
        if (conv) begin
          res_o.word = conv_word_i;
          res_o.kind = KIND_CONV;
        end
        if (class_q == CLS_METHOD && first_q && !pad_q) begin
          lits_d  = conv_word_i[LitW+2:3] & LitMask;
          first_d = 1'b0;
        end
        slots_d = slots_dec;
        if (slots_dec == '0) begin
          res_o.last = 1'b1;
          phase_d    = PH_START;
          pad_d      = 1'b0;
          first_d    = 1'b0;
          lits_d     = '0;
        end
      end
      default: begin
        if (phase_q != PH_HEADER && top == TopOverflow) begin
          res_o.kind = KIND_OVERFLOW;
          pending_d  = word_i[CountW-1:0];
          phase_d    = PH_HEADER;
        end else begin
          res_o.kind = KIND_HEADER;
          if (fmt <= FmtPtrMax || fmt == FmtWeakPtr) begin
            class_d = CLS_PTR;
          end else if (fmt >= FmtMethod) begin
            class_d = CLS_METHOD;
          end else begin
            class_d = CLS_RAW;
          end
          first_d = (class_d == CLS_METHOD);
          lits_d  = '0;
          pad_d   = (hdr_count == '0);
          slots_d = (hdr_count == '0) ? CountW'(1) : hdr_count;
          phase_d = PH_BODY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      pending_q <= '0;
      slots_q   <= '0;
      pad_q     <= 1'b0;
      class_q   <= CLS_RAW;
      lits_q    <= '0;
      first_q   <= 1'b0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      slots_q   <= slots_d;
      pad_q     <= pad_d;
      class_q   <= class_d;
      lits_q    <= lits_d;
      first_q   <= first_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hipr_checker.sv
// Port-level checks of the heap image pointer relocator, with bind.
`default_nettype none

module hipr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [hipr_pkg::WordW-1:0]   m_axis_tdata,
  input wire logic [1:0]                   m_axis_tuser,
  input wire logic                         m_axis_tlast,
  input wire logic                         cfg_ready_o
);
  import hipr_pkg::*;

  logic out_acc;
  logic prev_ovf_q, prev_hdr_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ovf_q <= 1'b0;
      prev_hdr_q <= 1'b0;
    end else if (out_acc) begin
      prev_ovf_q <= (m_axis_tuser == KIND_OVERFLOW);
      prev_hdr_q <= (m_axis_tuser == KIND_HEADER);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_last_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser == KIND_CONV || m_axis_tuser == KIND_PASS)
    else $error("object end flagged on a non-body word");

  a_ovf_then_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_ovf_q |-> m_axis_tuser == KIND_HEADER)
    else $error("overflow word not followed by a header");

  a_hdr_then_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_hdr_q |-> m_axis_tuser == KIND_CONV || m_axis_tuser == KIND_PASS)
    else $error("header not followed by a body word");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind heap_image_pointer_relocator hipr_checker u_hipr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the heap image pointer relocator.
`timescale 1ns / 100ps

module tb;
  import hipr_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseWords = 100;
  localparam logic [63:0] DirOld   = 64'h0000_1000_0000_0000;
  localparam logic [63:0] DirNew   = 64'h0000_7F00_0000_0000;
  localparam logic [63:0] DirBytes = 64'h0000_0000_0001_0000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata = '0;   // [63:0] heap_word
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [WordW-1:0]    m_axis_tdata;        // [63:0] word_out
  logic [1:0]          m_axis_tuser;        // [1:0] word_kind
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_OLD_BASE;
  logic [WordW-1:0]    cfg_data_i = '0;

  heap_image_pointer_relocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // heap words waiting to be sent, and relocated words waiting to come back
  logic [63:0] heap_words[$];
  hipr_res_t   relocated_words[$];

  bit steady = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int queued = 0;

  // mirror of the block's registers and parse state
  logic [63:0] old_base_q = '0;
  logic [63:0] new_base_q = '0;
  logic [47:0] heap_bytes_q = '0;
  phase_e      scan_phase = PH_START;
  logic [55:0] overflow_count = '0;
  logic [55:0] body_left = '0;
  logic        pad_word = 1'b0;
  obj_class_e  obj_kind = CLS_RAW;
  logic [15:0] lits_left = '0;
  logic        first_slot = 1'b0;

  function automatic logic [63:0] fix_pointer(logic [63:0] w);
    if (w == 64'd0 || w[0]) return w;
    if (w[2:0] == 3'd2) return {w[63:3], 3'd3};
    if (w[2:0] == 3'd4) return {w[63:3], 3'd5};
    if (w[2:0] != 3'd0) return w;
    // old range never wraps: below old_base is always left alone
    if (w >= old_base_q && (w - old_base_q) < {16'b0, heap_bytes_q})
      return w - old_base_q + new_base_q;
    return w;
  endfunction

  function automatic void open_object(logic [63:0] hdr, logic [55:0] count);
    logic [FmtW-1:0] fmt;
    fmt = hdr[FmtLsb +: FmtW];
    if (fmt <= FmtPtrMax || fmt == FmtWeakPtr) obj_kind = CLS_PTR;
    else if (fmt >= FmtMethod) obj_kind = CLS_METHOD;
    else obj_kind = CLS_RAW;
    first_slot = (obj_kind == CLS_METHOD);
    lits_left  = '0;
    pad_word   = (count == 56'd0);
    body_left  = pad_word ? 56'd1 : count;
    scan_phase = PH_BODY;
  endfunction

  function automatic hipr_res_t relocate_word(logic [63:0] w);
    hipr_res_t r;
    logic      conv;
    r.word = w;
    r.kind = KIND_PASS;
    r.last = 1'b0;
    conv   = 1'b0;
    if (scan_phase == PH_BODY) begin
      if (!pad_word) begin
        if (obj_kind == CLS_PTR) begin
          conv = 1'b1;
        end else if (obj_kind == CLS_METHOD) begin
          if (first_slot) begin
            conv = 1'b1;
          end else if (lits_left != 0) begin
            conv = 1'b1;
            lits_left = lits_left - 16'd1;
          end
        end
      end
      if (conv) begin
        r.word = fix_pointer(w);
        r.kind = KIND_CONV;
      end
      // literal count comes from the converted slot 0
      if (obj_kind == CLS_METHOD && first_slot && !pad_word) begin
        lits_left  = {1'b0, r.word[3 +: LitW] & LitMask};
        first_slot = 1'b0;
      end
      body_left = body_left - 56'd1;
      if (body_left == 56'd0) begin
        r.last     = 1'b1;
        scan_phase = PH_START;
        pad_word   = 1'b0;
        first_slot = 1'b0;
        lits_left  = '0;
      end
    end else if (scan_phase == PH_HEADER) begin
      r.kind = KIND_HEADER;
      open_object(w, (w[63:56] == TopOverflow) ? overflow_count : {48'b0, w[63:56]});
    end else if (w[63:56] == TopOverflow) begin
      r.kind         = KIND_OVERFLOW;
      overflow_count = w[55:0];
      scan_phase     = PH_HEADER;
    end else begin
      r.kind = KIND_HEADER;
      open_object(w, {48'b0, w[63:56]});
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] make_header(logic [7:0] top, logic [4:0] fmt,
                                              logic [63:0] fill);
    return {top, fill[55:29], fmt, fill[23:0]};
  endfunction

  // body word biased toward the conversion cases and the range edges
  function automatic logic [63:0] pick_slot();
    logic [63:0] r;
    logic [63:0] span;
    r    = rand64();
    span = {16'b0, heap_bytes_q};
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return r | 64'd1;
      2: return {r[63:3], 3'd2};
      3: return {r[63:3], 3'd4};
      4: return {r[63:3], 3'd6};
      5, 6: return (span == 0) ? {r[63:3], 3'd0} : old_base_q + ((r % span) & ~64'd7);
      7: begin
        case ($urandom_range(0, 3))
          0: return old_base_q;
          1: return old_base_q + span;
          2: return old_base_q - 64'd8;
          default: return old_base_q + span - 64'd8;
        endcase
      end
      default: return r;
    endcase
  endfunction

  task automatic push_word(logic [63:0] w);
    heap_words.push_back(w);
    queued++;
  endtask

  task automatic emit_object();
    int unsigned sel;
    int unsigned body;
    int unsigned lits;
    logic [4:0]  fmt;
    logic [55:0] count;
    logic [7:0]  top;
    logic [63:0] fill;
    logic [63:0] tmp;
    fill = rand64();
    case ($urandom_range(0, 2))
      0: begin
        fmt = 5'($urandom_range(0, 6));
        if (fmt == 5'd6) fmt = FmtWeakPtr;
      end
      1: fmt = 5'($urandom_range(24, 31));
      default: begin
        fmt = 5'($urandom_range(6, 23));
        if (fmt == FmtWeakPtr) fmt = 5'd10;
      end
    endcase
    count = 56'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8));
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      count = 56'($urandom_range(0, 60));
      push_word({TopOverflow, count});
      top = TopOverflow;
    end else if (sel == 1) begin
      // overflow word whose count the next header ignores
      tmp = rand64();
      push_word({TopOverflow, tmp[55:0]});
      top = count[7:0];
    end else if (sel == 2) begin
      top   = 8'($urandom_range(0, 40));
      count = {48'b0, top};
      fmt   = fill[28:24];
    end else begin
      top = count[7:0];
    end
    push_word(make_header(top, fmt, fill));
    body = (count == 0) ? 1 : int'(count);
    for (int unsigned i = 0; i < body; i++) begin
      if (i == 0 && count != 0 && fmt >= FmtMethod && $urandom_range(0, 3) != 0) begin
        lits = $urandom_range(0, body + 2);
        tmp  = rand64();
        push_word({tmp[63:18], lits[14:0], 3'b001});
      end else begin
        push_word(pick_slot());
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OLD_BASE:   old_base_q = val;
      REG_NEW_BASE:   new_base_q = val;
      REG_HEAP_BYTES: heap_bytes_q = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] old_b, logic [63:0] new_b, logic [63:0] bytes);
    write_reg(REG_OLD_BASE, old_b);
    write_reg(REG_NEW_BASE, new_b);
    write_reg(REG_HEAP_BYTES, bytes);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (heap_words.size() == 0 && relocated_words.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic random_phase();
    queued = 0;
    while (queued < PhaseWords) emit_object();
    drain();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin : drive_proc
    bit took;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        relocated_words.push_back(relocate_word(s_axis_tdata));
        void'(heap_words.pop_front());
      end
      if (!s_axis_tvalid || took) begin
        if (heap_words.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= heap_words[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_proc
    hipr_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (relocated_words.size() == 0) begin
          $error("unexpected word %h kind %0d last %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = relocated_words.pop_front();
          if (m_axis_tdata !== want.word) begin
            $error("word_out: expected %h, got %h", want.word, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("word_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("object_end: expected %0b, got %0b", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(DirOld, DirNew, DirBytes);
    // empty pointer object: pad word passes even if it looks like a pointer
    push_word(make_header(8'd0, 5'd0, '0));
    push_word(DirOld + 64'd8);
    // pointer object covering every conversion rule and the range edges
    push_word(make_header(8'd9, 5'd2, '0));
    push_word(64'd0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF);
    push_word(64'h0000_0000_1234_5672);
    push_word(64'h8000_0000_0000_0004);
    push_word(64'h0000_0000_0000_0006);
    push_word(DirOld);
    push_word(DirOld + DirBytes);
    push_word(DirOld - 64'd8);
    push_word(DirOld + DirBytes - 64'd8);
    // overflow count used by a method header: one literal, then a plain word
    push_word({TopOverflow, 56'd3});
    push_word(make_header(TopOverflow, 5'd24, '0));
    push_word(64'h0000_0000_0000_0009);
    push_word(DirOld + 64'd16);
    push_word(DirOld + 64'd24);
    // overflow count dropped by a header with its own count
    push_word({TopOverflow, 56'hAB_CDEF_0123_4567});
    push_word(make_header(8'd1, 5'd10, '0));
    push_word(DirOld + 64'd32);
    // literal count running past the end of the body
    push_word(make_header(8'd1, 5'd31, '0));
    push_word(64'h0000_0000_0003_FFF9);
    // zero overflow count gives a pad word
    push_word({TopOverflow, 56'd0});
    push_word(make_header(TopOverflow, 5'd3, '0));
    push_word(64'hDEAD_BEEF_0000_0002);
    drain();

    steady = 1'b1;
    random_phase();
    steady = 1'b0;

    set_config(64'hFFFF_FFFF_FFFF_F000, 64'd0, 64'h0000_FFFF_FFFF_FFFF);
    random_phase();
    set_config(64'd0, 64'hFFFF_FFFF_FFFF_FFF8, 64'd0);
    random_phase();
    set_config(64'd0, 64'h0123_4567_89AB_CDE8, 64'h0000_FFFF_FFFF_FFFF);
    random_phase();
    set_config(rand64() & ~64'd7, rand64(), rand64());
    random_phase();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
